### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and muted in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LPS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/lps_pkg.sv
// ---------------------------------------------------------------------------
// lps_pkg
// Shared constants and types of the line point stepper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lps_pkg;

   // Default coordinate width, signed two's complement.
   localparam int COORD_BITS_DEF = 12;

   // Request kinds carried in the req_type field.
   typedef enum logic {
      REQ_START   = 1'b0,
      REQ_ADVANCE = 1'b1
   } req_kind_type;

endpackage

### design/lps_ifs.sv
// ---------------------------------------------------------------------------
// lps_ifs
// Valid/ready channel interfaces for requests and emitted points.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lps_req_if #(
   parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   lps_pkg::req_kind_type        req_type;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, req_type, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lps_rsp_if #(
   parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

### design/line_point_stepper.sv
// ---------------------------------------------------------------------------
// line_point_stepper
// Four-connected line rasterizer: one axis moves one pixel per advance.
// ---------------------------------------------------------------------------
//  channel | role    | transfer moves
//  --------+---------+------------------------------------------------------
//  req_ch  | sink    | req_type, start_x, start_y, end_x, end_y
//  rsp_ch  | source  | point_x, point_y, last_point
//
//  Each request passes through the step decision and the state update,
//  which sit between the line state registers and the output register.
//  Throughput is one request per clock while the output side drains.
//  A two-entry output (register plus skid) lets a transfer in while a
//  point waits; req_ch.ready drops only while the skid entry is full.
//  Synchronous reset clears the line state, so advances emit nothing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module line_point_stepper #(
   parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lps_req_if.sink   req_ch,
   lps_rsp_if.source rsp_ch
);

   localparam int CB = COORD_BITS;

   typedef struct packed {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic          last;
   } pt_type;

   // Line state.
   logic [CB-1:0] cur_col_ff,    cur_col_in;
   logic [CB-1:0] cur_row_ff,    cur_row_in;
   logic [CB-1:0] target_col_ff, target_col_in;
   logic [CB-1:0] target_row_ff, target_row_in;
   logic [CB-1:0] span_col_ff,   span_col_in;
   logic [CB-1:0] span_row_ff,   span_row_in;
   logic          col_dir_neg_ff, col_dir_neg_in;
   logic          row_dir_neg_ff, row_dir_neg_in;
   logic [CB:0]   error_acc_ff,  error_acc_in;

   // Output register and skid entry.
   logic   out_valid_ff,  out_valid_in;
   logic   skid_valid_ff, skid_valid_in;
   pt_type out_ff,  out_in;
   pt_type skid_ff, skid_in;

   logic        accept;
   logic        pop;
   logic        emit;
   logic        push;
   pt_type      new_pt;
   logic [CB:0] dx;
   logic [CB:0] dy;
   logic [CB:0] abs_dx;
   logic [CB:0] abs_dy;
   logic [CB-1:0] col_step;
   logic [CB-1:0] row_step;
   logic [CB:0] span_sum;
   logic        idle_start;

   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = out_valid_ff && rsp_ch.ready;
   assign req_ch.ready = !skid_valid_ff;

   // Signed spans, one bit wider so the difference never wraps.
   assign dx = {req_ch.end_x[CB-1], req_ch.end_x} - {req_ch.start_x[CB-1], req_ch.start_x};
   assign dy = {req_ch.end_y[CB-1], req_ch.end_y} - {req_ch.start_y[CB-1], req_ch.start_y};
   assign abs_dx = dx[CB] ? (~dx + 1'b1) : dx;
   assign abs_dy = dy[CB] ? (~dy + 1'b1) : dy;

   // One pixel toward the target on each axis.
   assign col_step = col_dir_neg_ff ? (cur_col_ff - 1'b1) : (cur_col_ff + 1'b1);
   assign row_step = row_dir_neg_ff ? (cur_row_ff - 1'b1) : (cur_row_ff + 1'b1);

   // Step decision and line state update.
   always_comb begin
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      target_col_in  = target_col_ff;
      target_row_in  = target_row_ff;
      span_col_in    = span_col_ff;
      span_row_in    = span_row_ff;
      col_dir_neg_in = col_dir_neg_ff;
      row_dir_neg_in = row_dir_neg_ff;
      error_acc_in   = error_acc_ff;
      emit           = 1'b0;

      if (accept) begin
         case (req_ch.req_type)
            lps_pkg::REQ_START: begin
               // Latch a fresh line; any line in flight is dropped.
               cur_col_in     = req_ch.start_x;
               cur_row_in     = req_ch.start_y;
               target_col_in  = req_ch.end_x;
               target_row_in  = req_ch.end_y;
               span_col_in    = abs_dx[CB-1:0];
               span_row_in    = abs_dy[CB-1:0];
               col_dir_neg_in = dx[CB];
               row_dir_neg_in = dy[CB];
               error_acc_in   = '0;
            end
            lps_pkg::REQ_ADVANCE: begin
               if (cur_row_ff != target_row_ff) begin
                  emit = 1'b1;
                  if (span_col_ff == '0) begin
                     // Vertical line: rows only.
                     cur_row_in = row_step;
                  end else if (error_acc_ff > {1'b0, span_row_ff}) begin
                     cur_col_in   = col_step;
                     error_acc_in = error_acc_ff - {1'b0, span_row_ff};
                  end else begin
                     cur_row_in   = row_step;
                     error_acc_in = error_acc_ff + {1'b0, span_col_ff};
                  end
               end else if (cur_col_ff != target_col_ff) begin
                  // Row done: finish the columns.
                  emit       = 1'b1;
                  cur_col_in = col_step;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   assign new_pt.x    = cur_col_in;
   assign new_pt.y    = cur_row_in;
   assign new_pt.last = (cur_col_in == target_col_ff) && (cur_row_in == target_row_ff);
   assign push        = emit;

   // Output register plus skid: fill the register first, overflow into skid.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;

      if (skid_valid_ff) begin
         // No push can arrive here; drain skid into the register on pop.
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = new_pt;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = new_pt;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         target_col_ff  <= '0;
         target_row_ff  <= '0;
         span_col_ff    <= '0;
         span_row_ff    <= '0;
         col_dir_neg_ff <= 1'b0;
         row_dir_neg_ff <= 1'b0;
         error_acc_ff   <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         target_col_ff  <= target_col_in;
         target_row_ff  <= target_row_in;
         span_col_ff    <= span_col_in;
         span_row_ff    <= span_row_in;
         col_dir_neg_ff <= col_dir_neg_in;
         row_dir_neg_ff <= row_dir_neg_in;
         error_acc_ff   <= error_acc_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.point_x    = $signed(out_ff.x);
   assign rsp_ch.point_y    = $signed(out_ff.y);
   assign rsp_ch.last_point = out_ff.last;

   // Terms for the checks below.
   assign span_sum   = {1'b0, span_row_ff} + {1'b0, span_col_ff};
   assign idle_start = accept && (req_ch.req_type == lps_pkg::REQ_START) && !out_valid_ff;

   // The skid entry only fills behind a held output register.
   `LPS_ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full with output empty")

   // The error term stays within the sum of both spans.
   `LPS_ASSERT_IMPL(a_error_bounded, 1'b1, error_acc_ff <= span_sum, "error term out of range")

   // A start request never produces a point.
   `LPS_ASSERT_NEXT(a_start_silent, idle_start, !out_valid_ff, "start request emitted a point")

endmodule
